// File: rtl/core/gdfs_pkg.sv
package gdfs_pkg;

    // Fixed field widths of the item channels.
    localparam int KIND_W = 2;
    localparam int VERT_W = 6;

    // Largest vertex count the block supports.
    localparam int VMAX = 64;
    localparam int DEFAULT_MAX_VERTICES = 64;

    // Item kinds on the command channel.
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    // Control group for the adjacency memory.
    typedef struct packed {
        logic clear;
        logic rd_en;
        logic wr_en;
    } adj_ctrl_t;

    // Control group for the stack memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } stk_ctrl_t;

    // Index of the lowest set bit; zero when no bit is set.
    // The lowest bit is isolated with one add, then encoded by independent ORs.
    function automatic logic [VERT_W-1:0] lowest_index(input logic [VMAX-1:0] x);
        logic [VMAX-1:0]   iso;
        logic [VERT_W-1:0] idx;
        iso = x & (~x + VMAX'(1));
        idx = '0;
        for (int i = 0; i < VMAX; i++)
        begin
            if (iso[i])
            begin
                idx = idx | VERT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/core/gdfs_if.sv
interface gdfs_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [gdfs_pkg::KIND_W-1:0] kind;
    logic [gdfs_pkg::VERT_W-1:0] from_vertex;
    logic [gdfs_pkg::VERT_W-1:0] to_vertex;
    logic                        both_ways;
    logic [gdfs_pkg::VERT_W-1:0] start_vertex;

    modport source (
        output valid, kind, from_vertex, to_vertex, both_ways, start_vertex,
        input  ready
    );
    modport sink (
        input  valid, kind, from_vertex, to_vertex, both_ways, start_vertex,
        output ready
    );
endinterface

interface gdfs_res_if;
    logic                        valid;
    logic                        ready;
    logic [gdfs_pkg::VERT_W-1:0] vertex;
    logic                        last;

    modport source (
        output valid, vertex, last,
        input  ready
    );
    modport sink (
        input  valid, vertex, last,
        output ready
    );
endinterface

// File: rtl/core/gdfs_adj_mem.sv
module gdfs_adj_mem #(
    parameter int MAX_VERTICES = gdfs_pkg::DEFAULT_MAX_VERTICES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gdfs_pkg::adj_ctrl_t          ctrl,
    input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    input  logic [MAX_VERTICES-1:0]      wr_data,
    output logic [MAX_VERTICES-1:0]      rd_data
);
    logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic [MAX_VERTICES-1:0] row_valid_next;
    logic [MAX_VERTICES-1:0] rdata_reg;
    logic                    rvalid_reg;

    // A row that was never written since the last clear reads as zero.
    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (ctrl.clear)
        begin
            row_valid_next = '0;
        end
        else if (ctrl.wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            if (ctrl.rd_en)
            begin
                rvalid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

// File: rtl/core/gdfs_stack.sv
module gdfs_stack #(
    parameter int MAX_VERTICES = gdfs_pkg::DEFAULT_MAX_VERTICES
) (
    input  logic                            clk,
    input  gdfs_pkg::stk_ctrl_t             ctrl,
    input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    input  logic [$clog2(MAX_VERTICES)-1:0] wr_data,
    input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    output logic [$clog2(MAX_VERTICES)-1:0] rd_data
);
    localparam int AW = $clog2(MAX_VERTICES);

    logic [AW-1:0] mem [MAX_VERTICES];
    logic [AW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule

// File: rtl/core/graph_dfs_preorder.sv
// Channel  Dir  Payload                                              Accepted when
// cmd      in   kind, from_vertex, to_vertex, both_ways, start_vertex  valid && ready
// res      out  vertex, last                                         valid && ready
//
// A clear item is done as it is taken. An add edge item has one half, or two when
// both_ways is set, each half being a read and a write of one adjacency row.
// A search does a row read and a lowest-bit encode per visited vertex, plus a
// stack memory read per backtrack.
// Reset clears the row valid bits at once; no clearing pass is needed.
// A stalled result holds the search at a push or at its end, but not a backtrack;
// a new item is taken while the last result of a search waits in the output register.
module graph_dfs_preorder #(
    parameter int MAX_VERTICES = gdfs_pkg::DEFAULT_MAX_VERTICES
) (
    input  logic        clk,
    input  logic        rst_n,
    gdfs_cmd_if.sink    cmd,
    gdfs_res_if.source  res
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int DW = $clog2(MAX_VERTICES + 1);
    localparam logic [MAX_VERTICES-1:0] V_ONE = MAX_VERTICES'(1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_E1_RD  = 3'd1;
    localparam logic [2:0] ST_E1_WR  = 3'd2;
    localparam logic [2:0] ST_E2_RD  = 3'd3;
    localparam logic [2:0] ST_E2_WR  = 3'd4;
    localparam logic [2:0] ST_S_RD   = 3'd5;
    localparam logic [2:0] ST_S_EVAL = 3'd6;
    localparam logic [2:0] ST_P_LD   = 3'd7;

    logic [2:0]              state_reg, state_next;
    logic [DW-1:0]           depth_reg, depth_next;
    logic [AW-1:0]           top_reg, top_next;
    logic [AW-1:0]           pend_reg, pend_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [AW-1:0]           e_src_reg, e_src_next;
    logic [AW-1:0]           e_dst_reg, e_dst_next;
    logic                    e_both_reg, e_both_next;
    logic                    res_valid_reg, res_valid_next;
    logic [AW-1:0]           res_vertex_reg, res_vertex_next;
    logic                    res_last_reg, res_last_next;

    gdfs_pkg::adj_ctrl_t     adj_ctl;
    logic [AW-1:0]           adj_rd_addr;
    logic [AW-1:0]           adj_wr_addr;
    logic [MAX_VERTICES-1:0] adj_wr_data;
    logic [MAX_VERTICES-1:0] adj_rd_data;

    gdfs_pkg::stk_ctrl_t     stk_ctl;
    logic [AW-1:0]           stk_wr_addr;
    logic [AW-1:0]           stk_wr_data;
    logic [AW-1:0]           stk_rd_addr;
    logic [AW-1:0]           stk_rd_data;

    logic [MAX_VERTICES-1:0] open_bits;
    logic [gdfs_pkg::VMAX-1:0] open_wide;
    logic [AW-1:0]           next_w;
    logic [DW-1:0]           depth_m2;
    logic                    slot_free;
    logic                    emit;
    logic                    emit_last;
    logic                    cmd_take;

    gdfs_adj_mem #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_adj (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (adj_ctl),
        .rd_addr (adj_rd_addr),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data),
        .rd_data (adj_rd_data)
    );

    gdfs_stack #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_stack (
        .clk     (clk),
        .ctrl    (stk_ctl),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    // Unvisited neighbours of the vertex on top of the stack; the row read
    // lands in the cycle after it is issued, so this is meaningful in ST_S_EVAL.
    assign open_bits = adj_rd_data & ~visited_reg;
    assign open_wide = (gdfs_pkg::VMAX)'(open_bits);
    assign next_w    = AW'(gdfs_pkg::lowest_index(open_wide));
    assign depth_m2  = depth_reg - DW'(2);

    // The output register can take a new item when empty or being drained.
    assign slot_free = !res_valid_reg || res.ready;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_take  = cmd.valid && cmd.ready;

    always_comb
    begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        top_next     = top_reg;
        pend_next    = pend_reg;
        visited_next = visited_reg;
        e_src_next   = e_src_reg;
        e_dst_next   = e_dst_reg;
        e_both_next  = e_both_reg;

        adj_ctl     = '0;
        adj_rd_addr = top_reg;
        adj_wr_addr = e_src_reg;
        adj_wr_data = adj_rd_data | (V_ONE << e_dst_reg);

        stk_ctl     = '0;
        stk_wr_addr = depth_reg[AW-1:0];
        stk_wr_data = next_w;
        stk_rd_addr = depth_m2[AW-1:0];

        emit      = 1'b0;
        emit_last = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    case (cmd.kind)
                        gdfs_pkg::KIND_CLEAR:
                        begin
                            adj_ctl.clear = 1'b1;
                        end
                        gdfs_pkg::KIND_EDGE:
                        begin
                            // Edges naming a vertex out of range are dropped.
                            if (int'(cmd.from_vertex) < MAX_VERTICES
                                && int'(cmd.to_vertex) < MAX_VERTICES)
                            begin
                                e_src_next  = cmd.from_vertex[AW-1:0];
                                e_dst_next  = cmd.to_vertex[AW-1:0];
                                e_both_next = cmd.both_ways;
                                state_next  = ST_E1_RD;
                            end
                        end
                        gdfs_pkg::KIND_SEARCH:
                        begin
                            if (int'(cmd.start_vertex) < MAX_VERTICES)
                            begin
                                stk_ctl.wr_en = 1'b1;
                                stk_wr_addr   = '0;
                                stk_wr_data   = cmd.start_vertex[AW-1:0];
                                depth_next    = DW'(1);
                                top_next      = cmd.start_vertex[AW-1:0];
                                pend_next     = cmd.start_vertex[AW-1:0];
                                visited_next  = V_ONE << cmd.start_vertex[AW-1:0];
                                state_next    = ST_S_RD;
                            end
                        end
                        default:
                        begin
                            // The unused kind is taken and ignored.
                        end
                    endcase
                end
            end
            ST_E1_RD:
            begin
                adj_ctl.rd_en = 1'b1;
                adj_rd_addr   = e_src_reg;
                state_next    = ST_E1_WR;
            end
            ST_E1_WR:
            begin
                adj_ctl.wr_en = 1'b1;
                state_next    = e_both_reg ? ST_E2_RD : ST_IDLE;
            end
            ST_E2_RD:
            begin
                // The forward write has landed, so a self loop reads its new row.
                adj_ctl.rd_en = 1'b1;
                adj_rd_addr   = e_dst_reg;
                state_next    = ST_E2_WR;
            end
            ST_E2_WR:
            begin
                adj_ctl.wr_en = 1'b1;
                adj_wr_addr   = e_dst_reg;
                adj_wr_data   = adj_rd_data | (V_ONE << e_src_reg);
                state_next    = ST_IDLE;
            end
            ST_S_RD:
            begin
                adj_ctl.rd_en = 1'b1;
                state_next    = ST_S_EVAL;
            end
            ST_S_EVAL:
            begin
                if (open_bits != '0)
                begin
                    // Push the smallest open neighbour; the vertex found before
                    // it is now known not to be the last one and goes out.
                    if (slot_free)
                    begin
                        emit          = 1'b1;
                        pend_next     = next_w;
                        visited_next  = visited_reg | (V_ONE << next_w);
                        stk_ctl.wr_en = 1'b1;
                        depth_next    = depth_reg + DW'(1);
                        top_next      = next_w;
                        state_next    = ST_S_RD;
                    end
                end
                else if (depth_reg == DW'(1))
                begin
                    // Stack runs empty: the held vertex closes the search.
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        depth_next = '0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    stk_ctl.rd_en = 1'b1;
                    depth_next    = depth_reg - DW'(1);
                    state_next    = ST_P_LD;
                end
            end
            ST_P_LD:
            begin
                // The new top comes from the stack and addresses its row directly.
                adj_ctl.rd_en = 1'b1;
                adj_rd_addr   = stk_rd_data;
                top_next      = stk_rd_data;
                state_next    = ST_S_EVAL;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_vertex_next = res_vertex_reg;
        res_last_next   = res_last_reg;
        if (emit)
        begin
            res_valid_next  = 1'b1;
            res_vertex_next = pend_reg;
            res_last_next   = emit_last;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            visited_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            visited_reg   <= visited_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        pend_reg       <= pend_next;
        e_src_reg      <= e_src_next;
        e_dst_reg      <= e_dst_next;
        e_both_reg     <= e_both_next;
        res_vertex_reg <= res_vertex_next;
        res_last_reg   <= res_last_next;
    end

    assign res.valid  = res_valid_reg;
    assign res.vertex = gdfs_pkg::VERT_W'(res_vertex_reg);
    assign res.last   = res_last_reg;

    // The stack never holds more entries than there are vertices.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(depth_reg) <= MAX_VERTICES)
        else $error("stack depth exceeds vertex count");

    // Taking a new item means the previous search has fully unwound.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> depth_reg == '0)
        else $error("command accepted with search in progress");

    // Every search state works on a non-empty stack.
    a_search_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_S_RD || state_reg == ST_S_EVAL || state_reg == ST_P_LD)
        |-> depth_reg != '0)
        else $error("search running on an empty stack");

    // The closing item of a search returns the sequencer to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_last) |=> state_reg == ST_IDLE)
        else $error("search kept running after its final vertex");

endmodule
